// ===== rtl/aphm_pkg.sv =====
// Shared types, constants and codes of the averaging peak-hold level meter.
`default_nettype none

package aphm_pkg;

    // Field widths fixed by the interface
    localparam int LEVEL_BITS   = 16;
    localparam int RANGE_W      = 16;
    localparam int WLEN_W       = 7;
    localparam int SCNT_W       = 11;
    localparam int SEG_W        = 10;
    localparam int OP_W         = 2;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;

    // Storage sizes
    localparam int MAX_WINDOW   = 64;
    localparam int MAX_SEGMENTS = 1024;

    // Derived widths
    localparam int PTR_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int FILL_W  = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W   = LEVEL_BITS + FILL_W;
    localparam int DIFF_W  = ((LEVEL_BITS > RANGE_W) ? LEVEL_BITS : RANGE_W) + 1;
    localparam int PROD_W  = (DIFF_W - 1) + SCNT_W;
    localparam int DVD_W   = (PROD_W > SUM_W) ? PROD_W : SUM_W;
    localparam int DVS_W   = ((DIFF_W - 1) > FILL_W) ? (DIFF_W - 1) : FILL_W;
    localparam int DIV_CNT_W = $clog2(DVD_W + 1);

    // Reset values
    localparam logic signed [LEVEL_BITS-1:0] RESET_LEVEL     = LEVEL_BITS'(-10000);
    localparam logic signed [RANGE_W-1:0]    RESET_RANGE_LOW = RANGE_W'(-3000);
    localparam logic signed [RANGE_W-1:0]    RESET_RANGE_HIGH = '0;
    localparam logic [WLEN_W-1:0]            RESET_WLEN      = WLEN_W'(8);
    localparam logic [SCNT_W-1:0]            RESET_SCNT      = SCNT_W'(32);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WLEN       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCNT       = 3'd4;

    typedef enum logic [OP_W-1:0] {
        OP_SAMPLE   = 2'd0,
        OP_TICK     = 2'd1,
        OP_SET_BAR  = 2'd2,
        OP_SET_HOLD = 2'd3
    } op_t;

    typedef struct packed {
        op_t                           op;
        logic signed [LEVEL_BITS-1:0]  level;
    } in_item_t;

    typedef struct packed {
        logic signed [LEVEL_BITS-1:0]  bar_level;
        logic signed [LEVEL_BITS-1:0]  hold_level;
        logic [SEG_W-1:0]              lit_segment;
    } out_item_t;

    typedef struct packed {
        logic               start;
        logic [DVD_W-1:0]   dividend;
        logic [DVS_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [DVD_W-1:0]   quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/aphm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module aphm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                                    aclk,
    input  wire logic                                    wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                        wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output      logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/aphm_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none

module aphm_div (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire aphm_pkg::div_req_t div_req,
    output      aphm_pkg::div_rsp_t div_rsp
);

    logic                                 busy_reg, busy_next;
    logic                                 done_reg, done_next;
    logic [aphm_pkg::DIV_CNT_W-1:0]       count_reg, count_next;
    logic [aphm_pkg::DVS_W-1:0]           rem_reg, rem_next;
    logic [aphm_pkg::DVD_W-1:0]           quo_reg, quo_next;
    logic [aphm_pkg::DVS_W-1:0]           dvs_reg, dvs_next;

    logic [aphm_pkg::DVS_W:0]             shifted;
    logic [aphm_pkg::DVS_W:0]             diff;
    logic                                 ge;

    always_comb begin
        shifted = {rem_reg, quo_reg[aphm_pkg::DVD_W-1]};
        diff    = shifted - {1'b0, dvs_reg};
        ge      = (shifted >= {1'b0, dvs_reg});

        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dvs_next   = dvs_reg;

        if (div_req.start && !busy_reg) begin
            busy_next  = 1'b1;
            count_next = aphm_pkg::DIV_CNT_W'(aphm_pkg::DVD_W);
            rem_next   = '0;
            quo_next   = div_req.dividend;
            dvs_next   = div_req.divisor;
        end else if (busy_reg) begin
            rem_next   = ge ? diff[aphm_pkg::DVS_W-1:0] : shifted[aphm_pkg::DVS_W-1:0];
            quo_next   = {quo_reg[aphm_pkg::DVD_W-2:0], ge};
            count_next = count_reg - 1'b1;
            if (count_reg == aphm_pkg::DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign div_rsp.busy     = busy_reg;
    assign div_rsp.done     = done_reg;
    assign div_rsp.quotient = quo_reg;

endmodule

`default_nettype wire

// ===== rtl/averaging_peak_hold_level_meter_top.sv =====
// Level meter core: sequencer, window RAM and shared divider.
//
// Input items arrive on s_valid/s_ready with s_data (op, level); every item
// gives exactly one result on m_valid/m_ready with m_data (bar level, hold
// level, lit segment). Configuration is written through cfg_wr_en,
// cfg_index and cfg_wr_data; the user must write it only while no item is
// in flight, as the block itself does not enforce this.
// s_ready is high only while the sequencer is idle. A hold tick, a direct
// set or a sample in independent mode takes one serial division of 27
// quotient bits for the segment index; when the bar is not above the low
// end, lies above the high end, or the scale is empty or inverted, the
// division is skipped. An averaged sample adds, per dropped window entry,
// one RAM read and one subtract, then one final read, one write, one start
// and a second serial division for the average. Both divisions use the
// shared one-bit-per-cycle divider. The result sits in an output register;
// the next item is accepted while it waits, and the sequencer holds its
// finished result until the register is free when the receiver stalls.
// Reset (aresetn low, synchronous) empties the window, sets both levels to
// -10000 and loads the default configuration; no clearing pass is needed.
`default_nettype none

module averaging_peak_hold_level_meter_top (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output      logic                               s_ready,
    input  wire aphm_pkg::in_item_t                 s_data,
    output      logic                               m_valid,
    input  wire logic                               m_ready,
    output      aphm_pkg::out_item_t                m_data,
    input  wire logic                               cfg_wr_en,
    input  wire logic [aphm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [aphm_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);

    localparam int LB  = aphm_pkg::LEVEL_BITS;
    localparam int DW  = aphm_pkg::DIFF_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DROP_RD,
        S_DROP_SUB,
        S_WRITE,
        S_AVG_DIV,
        S_AVG_WAIT,
        S_SEG,
        S_SEG_WAIT,
        S_DONE
    } state_t;

    state_t                                   state_reg, state_next;
    aphm_pkg::in_item_t                       item_reg, item_next;
    aphm_pkg::out_item_t                      out_reg, out_next;
    logic                                     m_valid_reg, m_valid_next;

    logic                                     mode_reg, mode_next;
    logic signed [aphm_pkg::RANGE_W-1:0]      range_low_reg, range_low_next;
    logic signed [aphm_pkg::RANGE_W-1:0]      range_high_reg, range_high_next;
    logic [aphm_pkg::WLEN_W-1:0]              wlen_reg, wlen_next;
    logic [aphm_pkg::SCNT_W-1:0]              scnt_reg, scnt_next;

    logic signed [aphm_pkg::SUM_W-1:0]        sum_reg, sum_next;
    logic [aphm_pkg::FILL_W-1:0]              fill_reg, fill_next;
    logic [aphm_pkg::PTR_W-1:0]               ptr_reg, ptr_next;
    logic signed [LB-1:0]                     bar_reg, bar_next;
    logic signed [LB-1:0]                     hold_reg, hold_next;
    logic [aphm_pkg::SEG_W-1:0]               seg_reg, seg_next;

    // Datapath helpers
    logic [aphm_pkg::FILL_W-1:0]              eff_wl;
    logic [aphm_pkg::SCNT_W-1:0]              eff_cnt;
    logic [aphm_pkg::SCNT_W-1:0]              cnt_m1;
    logic signed [LB-1:0]                     item_level;
    logic signed [LB-1:0]                     ram_rdata;
    logic signed [aphm_pkg::SUM_W-1:0]        lv_ext;
    logic signed [aphm_pkg::SUM_W-1:0]        rd_ext;
    logic [aphm_pkg::PTR_W:0]                 slot_sum;
    logic [aphm_pkg::PTR_W-1:0]               slot;
    logic [aphm_pkg::PTR_W-1:0]               ptr_inc;
    logic                                     sum_neg;
    logic [aphm_pkg::SUM_W-1:0]               sum_mag;
    logic [LB-1:0]                            avg_mag;
    logic signed [LB-1:0]                     avg;
    logic signed [DW-1:0]                     avg_ext;
    logic signed [DW-1:0]                     bar_ext;
    logic signed [DW-1:0]                     low_ext;
    logic signed [DW-1:0]                     high_ext;
    logic signed [DW-1:0]                     span;
    logic signed [DW-1:0]                     bar_diff;
    logic                                     span_pos;
    logic                                     bar_gt_low;
    logic                                     bar_gt_high;
    logic                                     seg_in_range;
    logic [aphm_pkg::PROD_W-1:0]              prod;
    logic                                     ram_we;

    aphm_pkg::div_req_t                       div_req;
    aphm_pkg::div_rsp_t                       div_rsp;

    aphm_ram #(
        .WIDTH (LB),
        .DEPTH (aphm_pkg::MAX_WINDOW)
    ) u_window_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (slot),
        .wr_data (item_reg.level),
        .rd_addr (ptr_reg),
        .rd_data (ram_rdata)
    );

    aphm_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .div_req (div_req),
        .div_rsp (div_rsp)
    );

    // Effective window length and segment count
    always_comb begin
        if (wlen_reg == '0) begin
            eff_wl = aphm_pkg::FILL_W'(1);
        end else if (int'(wlen_reg) > aphm_pkg::MAX_WINDOW) begin
            eff_wl = aphm_pkg::FILL_W'(aphm_pkg::MAX_WINDOW);
        end else begin
            eff_wl = aphm_pkg::FILL_W'(wlen_reg);
        end

        if (scnt_reg == '0) begin
            eff_cnt = aphm_pkg::SCNT_W'(1);
        end else if (int'(scnt_reg) > aphm_pkg::MAX_SEGMENTS) begin
            eff_cnt = aphm_pkg::SCNT_W'(aphm_pkg::MAX_SEGMENTS);
        end else begin
            eff_cnt = scnt_reg;
        end
        cnt_m1 = eff_cnt - 1'b1;
    end

    // Window arithmetic
    always_comb begin
        item_level = item_reg.level;
        lv_ext  = {{(aphm_pkg::SUM_W-LB){item_level[LB-1]}}, item_level};
        rd_ext  = {{(aphm_pkg::SUM_W-LB){ram_rdata[LB-1]}}, ram_rdata};

        slot_sum = {1'b0, ptr_reg} + (aphm_pkg::PTR_W+1)'(fill_reg);
        if (slot_sum >= (aphm_pkg::PTR_W+1)'(aphm_pkg::MAX_WINDOW)) begin
            slot_sum = slot_sum - (aphm_pkg::PTR_W+1)'(aphm_pkg::MAX_WINDOW);
        end
        slot = slot_sum[aphm_pkg::PTR_W-1:0];

        if (ptr_reg == aphm_pkg::PTR_W'(aphm_pkg::MAX_WINDOW - 1)) begin
            ptr_inc = '0;
        end else begin
            ptr_inc = ptr_reg + 1'b1;
        end

        // Divide the magnitude and restore the sign: truncation toward zero
        sum_neg = sum_reg[aphm_pkg::SUM_W-1];
        sum_mag = sum_neg ? aphm_pkg::SUM_W'(-sum_reg) : aphm_pkg::SUM_W'(sum_reg);
        avg_mag = div_rsp.quotient[LB-1:0];
        avg     = sum_neg ? -avg_mag : avg_mag;
        avg_ext = {{(DW-LB){avg[LB-1]}}, avg};
    end

    // Segment arithmetic
    always_comb begin
        bar_ext  = {{(DW-LB){bar_reg[LB-1]}}, bar_reg};
        low_ext  = {{(DW-aphm_pkg::RANGE_W){range_low_reg[aphm_pkg::RANGE_W-1]}},
                    range_low_reg};
        high_ext = {{(DW-aphm_pkg::RANGE_W){range_high_reg[aphm_pkg::RANGE_W-1]}},
                    range_high_reg};
        span        = high_ext - low_ext;
        bar_diff    = bar_ext - low_ext;
        span_pos    = !span[DW-1] && (span != '0);
        bar_gt_low  = (bar_ext > low_ext);
        bar_gt_high = (bar_ext > high_ext);
        seg_in_range = span_pos && bar_gt_low && !bar_gt_high;
        prod = aphm_pkg::PROD_W'(bar_diff[DW-2:0]) * aphm_pkg::PROD_W'(eff_cnt);
    end

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        item_next       = item_reg;
        out_next        = out_reg;
        m_valid_next    = m_valid_reg;
        mode_next       = mode_reg;
        range_low_next  = range_low_reg;
        range_high_next = range_high_reg;
        wlen_next       = wlen_reg;
        scnt_next       = scnt_reg;
        sum_next        = sum_reg;
        fill_next       = fill_reg;
        ptr_next        = ptr_reg;
        bar_next        = bar_reg;
        hold_next       = hold_reg;
        seg_next        = seg_reg;
        ram_we          = 1'b0;

        div_req.start    = 1'b0;
        div_req.dividend = aphm_pkg::DVD_W'(prod);
        div_req.divisor  = aphm_pkg::DVS_W'(span[DW-2:0]);

        if (cfg_wr_en) begin
            unique case (cfg_index)
                aphm_pkg::CFG_MODE:       mode_next = cfg_wr_data[0];
                aphm_pkg::CFG_RANGE_LOW:  range_low_next = cfg_wr_data[aphm_pkg::RANGE_W-1:0];
                aphm_pkg::CFG_RANGE_HIGH: range_high_next = cfg_wr_data[aphm_pkg::RANGE_W-1:0];
                aphm_pkg::CFG_WLEN:       wlen_next = cfg_wr_data[aphm_pkg::WLEN_W-1:0];
                aphm_pkg::CFG_SCNT:       scnt_next = cfg_wr_data[aphm_pkg::SCNT_W-1:0];
                default: ;
            endcase
        end

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    item_next  = s_data;
                    state_next = S_SEG;
                    unique case (s_data.op)
                        aphm_pkg::OP_SAMPLE: begin
                            if (mode_reg) begin
                                state_next = S_DROP_RD;
                            end
                        end
                        aphm_pkg::OP_TICK: begin
                            hold_next = bar_reg;
                        end
                        aphm_pkg::OP_SET_BAR: begin
                            if (!mode_reg) begin
                                bar_next = s_data.level;
                            end
                        end
                        aphm_pkg::OP_SET_HOLD: begin
                            if (!mode_reg) begin
                                hold_next = s_data.level;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_DROP_RD: begin
                // RAM read of the oldest entry is under way
                if ((fill_reg >= eff_wl) && (fill_reg != '0)) begin
                    state_next = S_DROP_SUB;
                end else begin
                    state_next = S_WRITE;
                end
            end
            S_DROP_SUB: begin
                sum_next   = sum_reg - rd_ext;
                ptr_next   = ptr_inc;
                fill_next  = fill_reg - 1'b1;
                state_next = S_DROP_RD;
            end
            S_WRITE: begin
                ram_we     = 1'b1;
                sum_next   = sum_reg + lv_ext;
                fill_next  = fill_reg + 1'b1;
                state_next = S_AVG_DIV;
            end
            S_AVG_DIV: begin
                div_req.start    = 1'b1;
                div_req.dividend = aphm_pkg::DVD_W'(sum_mag);
                div_req.divisor  = aphm_pkg::DVS_W'(fill_reg);
                state_next       = S_AVG_WAIT;
            end
            S_AVG_WAIT: begin
                if (div_rsp.done) begin
                    if (avg != bar_reg) begin
                        bar_next = avg;
                        if (avg_ext < low_ext) begin
                            hold_next = avg;
                        end else if (avg > hold_reg) begin
                            hold_next = avg;
                        end
                    end
                    state_next = S_SEG;
                end
            end
            S_SEG: begin
                if (seg_in_range) begin
                    div_req.start = 1'b1;
                    state_next    = S_SEG_WAIT;
                end else begin
                    seg_next   = (span_pos && bar_gt_high) ? cnt_m1[aphm_pkg::SEG_W-1:0] : '0;
                    state_next = S_DONE;
                end
            end
            S_SEG_WAIT: begin
                if (div_rsp.done) begin
                    // Clamp to the last segment
                    if (div_rsp.quotient > aphm_pkg::DVD_W'(cnt_m1)) begin
                        seg_next = cnt_m1[aphm_pkg::SEG_W-1:0];
                    end else begin
                        seg_next = div_rsp.quotient[aphm_pkg::SEG_W-1:0];
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                // Hold the finished item until the output register is free
                if (!m_valid_reg || m_ready) begin
                    out_next.bar_level   = bar_reg;
                    out_next.hold_level  = hold_reg;
                    out_next.lit_segment = seg_reg;
                    m_valid_next         = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            m_valid_reg    <= 1'b0;
            mode_reg       <= 1'b0;
            range_low_reg  <= aphm_pkg::RESET_RANGE_LOW;
            range_high_reg <= aphm_pkg::RESET_RANGE_HIGH;
            wlen_reg       <= aphm_pkg::RESET_WLEN;
            scnt_reg       <= aphm_pkg::RESET_SCNT;
            sum_reg        <= '0;
            fill_reg       <= '0;
            ptr_reg        <= '0;
            bar_reg        <= aphm_pkg::RESET_LEVEL;
            hold_reg       <= aphm_pkg::RESET_LEVEL;
        end else begin
            state_reg      <= state_next;
            m_valid_reg    <= m_valid_next;
            mode_reg       <= mode_next;
            range_low_reg  <= range_low_next;
            range_high_reg <= range_high_next;
            wlen_reg       <= wlen_next;
            scnt_reg       <= scnt_next;
            sum_reg        <= sum_next;
            fill_reg       <= fill_next;
            ptr_reg        <= ptr_next;
            bar_reg        <= bar_next;
            hold_reg       <= hold_next;
        end
        item_reg <= item_next;
        out_reg  <= out_next;
        seg_reg  <= seg_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // The divider only finishes while the sequencer waits for it
    a_div_done_waited: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == S_AVG_WAIT) || (state_reg == S_SEG_WAIT))
        else $error("divider finished outside a wait state");

    // A start never lands on a busy divider
    a_div_start_free: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // After the drops there is room for the new sample
    a_window_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WRITE) |-> (fill_reg < eff_wl))
        else $error("window full at sample write");

    // A stalled result is never overwritten by the next item
    a_done_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE) && m_valid_reg && !m_ready |=> (state_reg == S_DONE))
        else $error("result register overwritten while stalled");

    // The shown segment never passes the last one
    a_seg_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (aphm_pkg::SCNT_W'(out_reg.lit_segment) < eff_cnt))
        else $error("lit segment beyond segment count");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for the level meter: directed table, then random phases.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import aphm_pkg::*;

    localparam int RANDOM_ITEMS   = 900;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 600;
    localparam int HOLD_AFTER     = 350;
    localparam int DRAIN_CYCLES   = 200;
    localparam int PRINT_CAP      = 100;

    typedef struct {
        bit                      is_cfg;
        logic [CFG_IDX_W-1:0]    idx;
        logic [CFG_DATA_W-1:0]   data;
        op_t                     op;
        logic [LEVEL_BITS-1:0]   level;
        bit                      known;
        out_item_t               want;
    } stim_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_item_t m_data;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    // Typed expectation travelling alongside the item on offer
    bit row_known = 1'b0;
    out_item_t row_want = '0;

    // Meter state as predicted
    logic signed [LEVEL_BITS-1:0] win_samples [MAX_WINDOW];
    longint win_total = 0;
    int win_count = 0;
    int win_head = 0;
    longint bar_now = longint'(RESET_LEVEL);
    longint hold_now = longint'(RESET_LEVEL);

    // Register copies as predicted
    bit mode_peak = 1'b0;
    longint scale_low = longint'(RESET_RANGE_LOW);
    longint scale_high = longint'(RESET_RANGE_HIGH);
    int win_len_reg = int'(RESET_WLEN);
    int seg_count_reg = int'(RESET_SCNT);

    out_item_t levels_due[$];
    stim_row_t stim_rows[$];

    int mismatch_count = 0;
    int results_checked = 0;
    int directed_items = 0;
    int random_items = 0;
    int cfg_writes = 0;
    int phases = 0;
    int burst_left = 0;
    int idle_cycles = 0;
    bit long_hold_done = 1'b0;

    averaging_peak_hold_level_meter_top DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    always #4 aclk = ~aclk;

    function automatic out_item_t predict_levels(in_item_t it);
        int wl, slot, cnt;
        longint avg, span, seg;
        out_item_t r;
        case (it.op)
            OP_SAMPLE: begin
                if (mode_peak) begin
                    wl = (win_len_reg < 1) ? 1 :
                         (win_len_reg > MAX_WINDOW) ? MAX_WINDOW : win_len_reg;
                    // drop oldest entries until the new sample fits
                    while (win_count >= wl && win_count > 0) begin
                        win_total -= win_samples[win_head];
                        win_head = (win_head + 1) % MAX_WINDOW;
                        win_count--;
                    end
                    slot = (win_head + win_count) % MAX_WINDOW;
                    win_samples[slot] = it.level;
                    win_total += it.level;
                    win_count++;
                    avg = win_total / win_count;
                    if (avg != bar_now) begin
                        bar_now = avg;
                        if (bar_now > hold_now) hold_now = bar_now;
                        if (bar_now < scale_low) hold_now = bar_now;
                    end
                end
            end
            OP_TICK: hold_now = bar_now;
            OP_SET_BAR: if (!mode_peak) bar_now = it.level;
            default: if (!mode_peak) hold_now = it.level;
        endcase
        cnt = (seg_count_reg < 1) ? 1 :
              (seg_count_reg > MAX_SEGMENTS) ? MAX_SEGMENTS : seg_count_reg;
        span = scale_high - scale_low;
        seg = 0;
        if (span > 0) begin
            if (bar_now > scale_low) seg = (bar_now - scale_low) * cnt / span;
            if (bar_now > scale_high) seg = cnt - 1;
        end
        if (seg > cnt - 1) seg = cnt - 1;
        if (seg < 0) seg = 0;
        r.bar_level = bar_now[LEVEL_BITS-1:0];
        r.hold_level = hold_now[LEVEL_BITS-1:0];
        r.lit_segment = seg[SEG_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what);
        mismatch_count++;
        // keep the log short when something is badly broken
        if (mismatch_count <= PRINT_CAP) $display("%0t ns mismatch: %s", $time, what);
    endtask

    // Monitor: take register writes and items into the predictor, check results
    always @(posedge aclk) begin
        out_item_t want, got;
        if (aresetn) begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_MODE:       mode_peak = cfg_wr_data[0];
                    CFG_RANGE_LOW:  scale_low = longint'($signed(cfg_wr_data));
                    CFG_RANGE_HIGH: scale_high = longint'($signed(cfg_wr_data));
                    CFG_WLEN:       win_len_reg = int'(cfg_wr_data[WLEN_W-1:0]);
                    CFG_SCNT:       seg_count_reg = int'(cfg_wr_data[SCNT_W-1:0]);
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                got = m_data;
                if (levels_due.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with no item outstanding",
                                              results_checked));
                end else begin
                    want = levels_due.pop_front();
                    if (got.bar_level !== want.bar_level)
                        report_mismatch($sformatf("result %0d bar_level %0d, want %0d",
                            results_checked, got.bar_level, want.bar_level));
                    if (got.hold_level !== want.hold_level)
                        report_mismatch($sformatf("result %0d hold_level %0d, want %0d",
                            results_checked, got.hold_level, want.hold_level));
                    if (got.lit_segment !== want.lit_segment)
                        report_mismatch($sformatf("result %0d lit_segment %0d, want %0d",
                            results_checked, got.lit_segment, want.lit_segment));
                end
                results_checked++;
            end
            if (s_valid && s_ready) begin
                want = predict_levels(s_data);
                if (row_known) want = row_want;
                levels_due = {levels_due, want};
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                         idle_cycles, levels_due.size());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Receiver: stall on styles of its own, and hold off once for a long stretch
    initial begin
        int style_left, style;
        style_left = 0;
        style = 0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (!long_hold_done && results_checked >= HOLD_AFTER) begin
                long_hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
            end
            if (style_left == 0) begin
                style = $urandom_range(0, 2);
                style_left = $urandom_range(20, 200);
            end
            style_left--;
            case (style)
                0: m_ready <= 1'b1;
                1: m_ready <= 1'($urandom_range(0, 1));
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, int data);
        stim_row_t r;
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.data = 16'(data);
        r.op = OP_TICK;
        r.level = '0;
        r.known = 1'b0;
        r.want = '0;
        return r;
    endfunction

    function automatic stim_row_t item_row(op_t op, int level, bit known = 1'b0,
                                           int bar = 0, int hold = 0, int seg = 0);
        stim_row_t r;
        r.is_cfg = 1'b0;
        r.idx = '0;
        r.data = '0;
        r.op = op;
        r.level = 16'(level);
        r.known = known;
        r.want.bar_level = 16'(bar);
        r.want.hold_level = 16'(hold);
        r.want.lit_segment = 10'(seg);
        return r;
    endfunction

    // Append one row to the directed table
    function automatic void add_row(stim_row_t r);
        stim_rows = {stim_rows, r};
    endfunction

    // Offer one item and hold it until accepted; returns on the following falling edge
    task automatic send_item(op_t op, logic [LEVEL_BITS-1:0] level, bit known,
                             out_item_t want);
        in_item_t it;
        it.op = op;
        it.level = level;
        s_data <= it;
        s_valid <= 1'b1;
        row_known <= known;
        row_want <= want;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Burst pacing: random burst lengths, random gaps between bursts
    task automatic pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(1, 30);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    // Stop offering and wait until every result is back
    task automatic settle();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (levels_due.size() != 0) @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= data;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
        cfg_writes++;
    endtask

    task automatic random_setup(bit peak);
        int a, b, lo, hi, wl, sc;
        settle();
        a = int'($urandom_range(0, 65535)) - 32768;
        b = int'($urandom_range(0, 65535)) - 32768;
        case ($urandom_range(0, 5))
            0: begin lo = -3000; hi = 0; end
            1: begin lo = -32768; hi = 32767; end
            2: begin lo = a; hi = a; end
            3: begin lo = (a > b) ? a : b; hi = (a > b) ? b : a; end
            default: begin lo = (a < b) ? a : b; hi = (a < b) ? b : a; end
        endcase
        case ($urandom_range(0, 7))
            0: wl = 0;
            1: wl = 1;
            2: wl = MAX_WINDOW;
            3: wl = 127;
            4: wl = 2;
            default: wl = $urandom_range(1, MAX_WINDOW);
        endcase
        case ($urandom_range(0, 7))
            0: sc = 0;
            1: sc = 1;
            2: sc = MAX_SEGMENTS;
            3: sc = 2047;
            4: sc = MAX_SEGMENTS + 1;
            default: sc = $urandom_range(1, MAX_SEGMENTS);
        endcase
        write_reg(CFG_MODE, {15'd0, peak});
        write_reg(CFG_RANGE_LOW, 16'(lo));
        write_reg(CFG_RANGE_HIGH, 16'(hi));
        write_reg(CFG_WLEN, 16'(wl));
        write_reg(CFG_SCNT, 16'(sc));
    endtask

    function automatic op_t pick_op(bit peak);
        int r;
        r = $urandom_range(0, 9);
        if (peak) begin
            if (r < 8) return OP_SAMPLE;
            if (r == 8) return OP_TICK;
            return ($urandom_range(0, 1) != 0) ? OP_SET_BAR : OP_SET_HOLD;
        end
        if (r < 4) return OP_SET_BAR;
        if (r < 7) return OP_SET_HOLD;
        if (r < 9) return OP_TICK;
        return OP_SAMPLE;
    endfunction

    // Levels: extremes, values around the scale, and anything at all
    function automatic logic [LEVEL_BITS-1:0] pick_level();
        longint lo, hi, v;
        lo = ((scale_low < scale_high) ? scale_low : scale_high) - 40;
        hi = ((scale_low < scale_high) ? scale_high : scale_low) + 40;
        if (lo < -32768) lo = -32768;
        if (hi > 32767) hi = 32767;
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2, 3, 4: begin
                v = lo + longint'($urandom_range(0, int'(hi - lo)));
                return v[LEVEL_BITS-1:0];
            end
            default: return 16'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    initial begin
        int n;
        bit peak;
        out_item_t none;
        stim_row_t row;
        none = '0;

        // Defaults after reset: independent mode, scale -3000..0, 32 segments
        add_row(item_row(OP_TICK, 0, 1, -10000, -10000, 0));
        add_row(item_row(OP_SET_BAR, 32767, 1, 32767, -10000, 31));
        add_row(item_row(OP_SET_HOLD, -32768, 1, 32767, -32768, 31));
        add_row(item_row(OP_SAMPLE, 1234, 1, 32767, -32768, 31));
        add_row(item_row(OP_SET_BAR, -1500, 1, -1500, -32768, 16));
        add_row(item_row(OP_TICK, -1, 1, -1500, -1500, 16));
        add_row(item_row(OP_SET_BAR, -32768, 1, -32768, -1500, 0));
        // Peak mode, full scale, short window
        add_row(cfg_row(CFG_MODE, 1));
        add_row(cfg_row(CFG_WLEN, 3));
        add_row(cfg_row(CFG_SCNT, MAX_SEGMENTS));
        add_row(cfg_row(CFG_RANGE_LOW, -32768));
        add_row(cfg_row(CFG_RANGE_HIGH, 32767));
        add_row(item_row(OP_SET_BAR, 100, 1, -32768, -1500, 0));
        add_row(item_row(OP_SAMPLE, 32767, 1, 32767, 32767, 1023));
        add_row(item_row(OP_SAMPLE, 32767));
        add_row(item_row(OP_SAMPLE, -32768));
        add_row(item_row(OP_SAMPLE, -32768));
        add_row(item_row(OP_SAMPLE, -32768));
        add_row(item_row(OP_SET_HOLD, 5));
        add_row(item_row(OP_TICK, 0));
        // Shrink the window to one, empty scale
        add_row(cfg_row(CFG_WLEN, 1));
        add_row(cfg_row(CFG_RANGE_LOW, 0));
        add_row(cfg_row(CFG_RANGE_HIGH, 0));
        add_row(item_row(OP_SAMPLE, -5));
        add_row(item_row(OP_SAMPLE, 7));
        // Zero window and segment count, inverted scale
        add_row(cfg_row(CFG_WLEN, 0));
        add_row(cfg_row(CFG_SCNT, 0));
        add_row(cfg_row(CFG_RANGE_LOW, 100));
        add_row(cfg_row(CFG_RANGE_HIGH, -100));
        add_row(item_row(OP_SAMPLE, 50));
        add_row(item_row(OP_SAMPLE, -50));
        // Oversized window and segment count, default scale
        add_row(cfg_row(CFG_WLEN, 100));
        add_row(cfg_row(CFG_SCNT, 2047));
        add_row(cfg_row(CFG_RANGE_LOW, -3000));
        add_row(cfg_row(CFG_RANGE_HIGH, 0));
        add_row(item_row(OP_SAMPLE, -3001));
        add_row(item_row(OP_SAMPLE, -2999));
        add_row(item_row(OP_SAMPLE, 1));
        add_row(item_row(OP_TICK, 0));
        add_row(cfg_row(CFG_MODE, 0));
        add_row(item_row(OP_SET_HOLD, 32767));
        add_row(item_row(OP_SAMPLE, 0));

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (stim_rows[i]) begin
            row = stim_rows[i];
            if (row.is_cfg) begin
                settle();
                write_reg(row.idx, row.data);
            end else begin
                send_item(row.op, row.level, row.known, row.want);
                directed_items++;
                pace();
            end
        end

        while (random_items < RANDOM_ITEMS) begin
            // favour peak mode, where the window holds most of the behaviour
            peak = ($urandom_range(0, 2) != 0);
            random_setup(peak);
            phases++;
            n = $urandom_range(40, 110);
            for (int k = 0; k < n; k++) begin
                send_item(pick_op(peak), pick_level(), 1'b0, none);
                random_items++;
                pace();
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (levels_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", levels_due.size()));

        $display("covered %0d directed and %0d random items in %0d random settings",
                 directed_items, random_items, phases);
        $display("%0d results checked, %0d register writes, long receiver hold %s",
                 results_checked, cfg_writes, long_hold_done ? "done" : "not reached");
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== averaging_peak_hold_level_meter_top.f =====
rtl/aphm_pkg.sv
rtl/aphm_ram.sv
rtl/aphm_div.sv
rtl/averaging_peak_hold_level_meter_top.sv
test/tb_top.sv
